### design/mbt_pkg.sv
// shared constants, command codes, result type and helpers for the bag table
`default_nettype none

package mbt_pkg;

  // table geometry
  localparam int CAPACITY   = 16;
  localparam int ITEM_WIDTH = 32;
  localparam int IDX_W      = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W      = $clog2(CAPACITY + 1);

  // fixed port field widths
  localparam int CMD_W     = 3;
  localparam int IN_ITEM_W = 32;
  localparam int OUT_VAL_W = 32;
  localparam int TOT_W     = 5;

  // command codes
  localparam logic [CMD_W-1:0] CMD_ADD    = 3'd0;
  localparam logic [CMD_W-1:0] CMD_REMOVE = 3'd1;
  localparam logic [CMD_W-1:0] CMD_COUNT  = 3'd2;
  localparam logic [CMD_W-1:0] CMD_LIST   = 3'd3;
  localparam logic [CMD_W-1:0] CMD_CLEAR  = 3'd4;

  // one result beat
  typedef struct packed {
    logic                 ok;
    logic [TOT_W-1:0]     match_count;
    logic [TOT_W-1:0]     entry_total;
    logic [OUT_VAL_W-1:0] entry_value;
    logic                 entry_valid;
    logic                 last;
  } mbt_res_t;

  // saturating narrow of a count onto the five-bit result fields
  function automatic logic [TOT_W-1:0] sat_tot(input logic [CNT_W-1:0] v);
    logic [TOT_W-1:0] r;
    if (int'(v) > 31) begin
      r = 5'd31;
    end else begin
      r = TOT_W'(v);
    end
    return r;
  endfunction

endpackage

`default_nettype wire

### design/mbt_if.sv
// request and result channel interfaces of the bag table
`default_nettype none

interface mbt_req_if import mbt_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CMD_W-1:0]     cmd;
  logic [IN_ITEM_W-1:0] item_value;

  modport source (output valid, cmd, item_value, input ready);
  modport sink (input valid, cmd, item_value, output ready);
endinterface

interface mbt_rsp_if import mbt_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic                 ok;
  logic [TOT_W-1:0]     match_count;
  logic [TOT_W-1:0]     entry_total;
  logic [OUT_VAL_W-1:0] entry_value;
  logic                 entry_valid;
  logic                 last;

  modport source (output valid, ok, match_count, entry_total, entry_value, entry_valid,
                  last, input ready);
  modport sink (input valid, ok, match_count, entry_total, entry_value, entry_valid,
                last, output ready);
endinterface

`default_nettype wire

### design/multiset_bag_table.sv
// top level of the bounded multiset table with its result output register
//
//  channel | dir | beat contents
//  req     | in  | cmd, item_value
//  rsp     | out | ok, match_count, entry_total, entry_value, entry_valid, last
//
// add, clear and unknown commands go from accept straight to the emit step.
// remove and count scan the entry memory newest first through its single read
// port; list reads each entry through its list and data steps, newest first.
// rst clears the entry count but never the entry memory itself.
// a new command is taken while the last result waits in the output register;
// a stalled result holds the sequencer in its emit step.
`default_nettype none

module multiset_bag_table import mbt_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  mbt_req_if.sink   req,
  mbt_rsp_if.source rsp
);

  mbt_res_t res;
  mbt_res_t res_q;
  logic     emit;
  logic     room;
  logic     out_valid;

  mbt_seq u_seq (
    .clk  (clk),
    .rst  (rst),
    .req  (req),
    .res  (res),
    .emit (emit),
    .room (room)
  );

  // output register parts the sequencer from the result consumer
  assign room = !out_valid || rsp.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit && room) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit && room) begin
      res_q <= res;
    end
  end

  assign rsp.valid       = out_valid;
  assign rsp.ok          = res_q.ok;
  assign rsp.match_count = res_q.match_count;
  assign rsp.entry_total = res_q.entry_total;
  assign rsp.entry_value = res_q.entry_value;
  assign rsp.entry_valid = res_q.entry_valid;
  assign rsp.last        = res_q.last;

endmodule

`default_nettype wire

### design/mbt_ram.sv
// generic single-write, single-read synchronous ram with registered read data
`default_nettype none

module mbt_ram #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 32,
  parameter int AW    = 4
) (
  input  wire logic             clk,
  input  wire logic             wr_en,
  input  wire logic [AW-1:0]    wr_addr,
  input  wire logic [WIDTH-1:0] wr_data,
  input  wire logic [AW-1:0]    rd_addr,
  output logic      [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // read port, registered read data
  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

`default_nettype wire

### design/mbt_seq.sv
// command sequencer: scans, lists and updates the entry memory
`default_nettype none

module mbt_seq import mbt_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  mbt_req_if.sink   req,
  output mbt_res_t  res,
  output logic      emit,
  input  wire logic room
);

  typedef enum logic [2:0] {IDLE, SCAN, LIST, LDATA, EMIT} state_t;

  state_t                 state;
  logic [CMD_W-1:0]       cmd_r;
  logic [ITEM_WIDTH-1:0]  item_r;
  logic [CNT_W-1:0]       count;
  logic [CNT_W-1:0]       idx;
  logic [CNT_W-1:0]       idx_dec;
  logic [CNT_W-1:0]       match_cnt;
  logic                   chk;
  logic                   first;
  logic [IDX_W-1:0]       chk_idx;
  logic [ITEM_WIDTH-1:0]  newest_r;
  logic                   ok_r;
  logic [OUT_VAL_W-1:0]   value_r;
  logic                   valid_r;
  logic                   last_r;

  logic                   wr_en;
  logic [IDX_W-1:0]       wr_addr;
  logic [ITEM_WIDTH-1:0]  wr_data;
  logic [IDX_W-1:0]       rd_addr;
  logic [ITEM_WIDTH-1:0]  rd_data;
  logic                   hit;
  logic                   has_room;

  // entry store
  mbt_ram #(
    .DEPTH (CAPACITY),
    .WIDTH (ITEM_WIDTH),
    .AW    (IDX_W)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // read pointer walks from newest towards oldest
  assign idx_dec  = idx - CNT_W'(1);
  assign rd_addr  = idx_dec[IDX_W-1:0];
  assign hit      = chk && (rd_data == item_r);
  assign has_room = count < CNT_W'(CAPACITY);

  assign req.ready = (state == IDLE);

  // write port: add appends, remove moves the newest entry into the hole
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = count[IDX_W-1:0];
    wr_data = ITEM_WIDTH'(req.item_value);
    if (state == IDLE && req.valid && req.cmd == CMD_ADD && has_room) begin
      wr_en = 1'b1;
    end else if (state == SCAN && cmd_r == CMD_REMOVE && hit) begin
      wr_en   = 1'b1;
      wr_addr = chk_idx;
      wr_data = first ? rd_data : newest_r;
    end
  end

  // result beat towards the output register
  assign emit            = (state == EMIT);
  assign res.ok          = ok_r;
  assign res.match_count = sat_tot(match_cnt);
  assign res.entry_total = sat_tot(count);
  assign res.entry_value = value_r;
  assign res.entry_valid = valid_r;
  assign res.last        = last_r;

  // state, count and registered result fields
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
      count <= '0;
      chk   <= 1'b0;
      first <= 1'b0;
    end else begin
      unique case (state)
        IDLE: begin
          if (req.valid) begin
            cmd_r     <= req.cmd;
            item_r    <= ITEM_WIDTH'(req.item_value);
            match_cnt <= '0;
            value_r   <= '0;
            valid_r   <= 1'b0;
            last_r    <= 1'b1;
            idx       <= count;
            chk       <= 1'b0;
            first     <= 1'b1;
            unique case (req.cmd) inside
              CMD_ADD: begin
                ok_r  <= has_room;
                if (has_room) begin
                  count <= count + CNT_W'(1);
                end
                state <= EMIT;
              end
              CMD_REMOVE, CMD_COUNT: begin
                ok_r  <= 1'b0;
                state <= SCAN;
              end
              CMD_LIST: begin
                ok_r  <= 1'b1;
                state <= (count == '0) ? EMIT : LIST;
              end
              CMD_CLEAR: begin
                ok_r  <= 1'b1;
                count <= '0;
                state <= EMIT;
              end
              default: begin
                ok_r  <= 1'b0;
                state <= EMIT;
              end
            endcase
          end
        end
        SCAN: begin
          // issue the next read while checking the one in flight
          chk     <= (idx != '0);
          chk_idx <= rd_addr;
          if (idx != '0) begin
            idx <= idx_dec;
          end
          if (chk) begin
            first <= 1'b0;
            if (first) begin
              newest_r <= rd_data;
            end
          end
          if (hit) begin
            ok_r <= 1'b1;
            if (cmd_r == CMD_REMOVE) begin
              count <= count - CNT_W'(1);
              state <= EMIT;
            end else begin
              match_cnt <= match_cnt + CNT_W'(1);
            end
          end
          if (!chk && idx == '0) begin
            state <= EMIT;
          end
        end
        LIST: begin
          state <= LDATA;
        end
        LDATA: begin
          value_r <= OUT_VAL_W'(rd_data);
          valid_r <= 1'b1;
          last_r  <= (idx == CNT_W'(1));
          idx     <= idx_dec;
          state   <= EMIT;
        end
        EMIT: begin
          if (room) begin
            state <= (cmd_r == CMD_LIST && !last_r) ? LIST : IDLE;
          end
        end
        default: begin
          state <= IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

### sim/bag_table_checker.sv
// result checker for the bag table: watches both channels, predicts every beat and compares
`default_nettype none

module bag_table_checker import mbt_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  mbt_req_if        req,
  mbt_rsp_if        rsp,
  output int        fail_count,
  output int        beats_owed
);

  // predicted table contents, slot 0 oldest
  logic [ITEM_WIDTH-1:0] bag [CAPACITY];
  int                    bag_size;
  mbt_res_t              owed_beats [$];

  // one result beat, entry_total taken from the current size
  function automatic mbt_res_t make_beat(input logic ok, input int hits,
                                         input logic [ITEM_WIDTH-1:0] value,
                                         input logic valid, input logic fin);
    mbt_res_t b;
    b.ok          = ok;
    b.match_count = (hits > 31) ? TOT_W'(31) : TOT_W'(hits);
    b.entry_total = (bag_size > 31) ? TOT_W'(31) : TOT_W'(bag_size);
    b.entry_value = OUT_VAL_W'(value);
    b.entry_valid = valid;
    b.last        = fin;
    return b;
  endfunction

  // append one predicted beat at the tail of the queue
  task automatic queue_beat(input mbt_res_t b);
    owed_beats = {owed_beats, b};
  endtask

  // update the predicted table and queue the beats one command causes
  task automatic apply_command(input logic [CMD_W-1:0] c, input logic [IN_ITEM_W-1:0] raw);
    logic [ITEM_WIDTH-1:0] item;
    int                    hits;
    int                    slot;
    int                    i;
    item = raw[ITEM_WIDTH-1:0];
    hits = 0;
    slot = -1;
    case (c)
      CMD_ADD: begin
        if (bag_size < CAPACITY) begin
          bag[bag_size] = item;
          bag_size++;
          queue_beat(make_beat(1'b1, 0, '0, 1'b0, 1'b1));
        end else begin
          queue_beat(make_beat(1'b0, 0, '0, 1'b0, 1'b1));
        end
      end
      CMD_REMOVE: begin
        // newest match wins, the newest entry fills the hole
        for (i = bag_size - 1; i >= 0; i--) begin
          if (slot < 0 && bag[i] == item) slot = i;
        end
        if (slot >= 0) begin
          bag[slot] = bag[bag_size - 1];
          bag_size--;
        end
        queue_beat(make_beat(slot >= 0, 0, '0, 1'b0, 1'b1));
      end
      CMD_COUNT: begin
        for (i = 0; i < bag_size; i++) begin
          if (bag[i] == item) hits++;
        end
        queue_beat(make_beat(hits > 0, hits, '0, 1'b0, 1'b1));
      end
      CMD_LIST: begin
        if (bag_size == 0) begin
          queue_beat(make_beat(1'b1, 0, '0, 1'b0, 1'b1));
        end else begin
          for (i = bag_size - 1; i >= 0; i--) begin
            queue_beat(make_beat(1'b1, 0, bag[i], 1'b1, i == 0));
          end
        end
      end
      CMD_CLEAR: begin
        bag_size = 0;
        queue_beat(make_beat(1'b1, 0, '0, 1'b0, 1'b1));
      end
      default: begin
        queue_beat(make_beat(1'b0, 0, '0, 1'b0, 1'b1));
      end
    endcase
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected %0h, actual %0h", name, want, got);
      fail_count++;
    end
  endtask

  // result beats are checked before a request beat of the same edge is predicted
  always @(posedge clk) begin
    mbt_res_t want;
    if (rst) begin
      owed_beats.delete();
      bag_size   = 0;
      fail_count = 0;
    end else begin
      if (rsp.valid && rsp.ready) begin
        if (owed_beats.size() == 0) begin
          $error("result beat with no expected result waiting");
          fail_count++;
        end else begin
          want = owed_beats.pop_front();
          check_field("ok", 32'(want.ok), 32'(rsp.ok));
          check_field("match_count", 32'(want.match_count), 32'(rsp.match_count));
          check_field("entry_total", 32'(want.entry_total), 32'(rsp.entry_total));
          check_field("entry_value", 32'(want.entry_value), 32'(rsp.entry_value));
          check_field("entry_valid", 32'(want.entry_valid), 32'(rsp.entry_valid));
          check_field("last", 32'(want.last), 32'(rsp.last));
        end
      end
      if (req.valid && req.ready) apply_command(req.cmd, req.item_value);
    end
    beats_owed <= owed_beats.size();
  end

endmodule

`default_nettype wire

### sim/testbench.sv
// top of the bag table testbench: clock, reset, command stimulus, result stalls and verdict
`default_nettype none

module testbench;
  import mbt_pkg::*;

  localparam int RANDOM_ITEMS  = 470;
  localparam int CYCLE_LIMIT   = 400000;
  localparam int SETTLE_CYCLES = 64;
  localparam int IDLE_PCT      = 38;
  localparam int POOL_SIZE     = 5;

  // codes the block does not implement
  localparam logic [CMD_W-1:0] CMD_SPARE_LO = 3'd5;
  localparam logic [CMD_W-1:0] CMD_SPARE_HI = 3'd7;

  localparam logic [IN_ITEM_W-1:0] ALL_ONES = '1;

  logic clk = 1'b0;
  logic rst;
  logic calm;
  int   cycles = 0;
  int   sent;
  int   fail_count;
  int   beats_owed;

  // values reused often so that removes and counts find matches
  logic [IN_ITEM_W-1:0] pool [POOL_SIZE];

  mbt_req_if req_ch ();
  mbt_rsp_if rsp_ch ();

  multiset_bag_table i_dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  bag_table_checker i_checker (
    .clk        (clk),
    .rst        (rst),
    .req        (req_ch),
    .rsp        (rsp_ch),
    .fail_count (fail_count),
    .beats_owed (beats_owed)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // run limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("testbench NOT OK");
      $finish;
    end
  end

  // result side stalls, none during the calm stretch
  initial begin
    rsp_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      rsp_ch.ready <= calm || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  function automatic void refresh_pool();
    int i;
    for (i = 0; i < POOL_SIZE; i++) begin
      case ($urandom_range(5))
        0:       pool[i] = '0;
        1:       pool[i] = ALL_ONES;
        default: pool[i] = $urandom;
      endcase
    end
  endfunction

  function automatic logic [IN_ITEM_W-1:0] pick_value();
    logic [IN_ITEM_W-1:0] v;
    if ($urandom_range(99) < 70) begin
      v = pool[$urandom_range(POOL_SIZE - 1)];
    end else begin
      v = $urandom;
    end
    return v;
  endfunction

  // one request beat, with random idle cycles ahead of it
  task automatic send_beat(input logic [CMD_W-1:0] c, input logic [IN_ITEM_W-1:0] v);
    while (!calm && $urandom_range(99) < IDLE_PCT) begin
      req_ch.valid <= 1'b0;
      @(posedge clk);
    end
    req_ch.valid      <= 1'b1;
    req_ch.cmd        <= c;
    req_ch.item_value <= v;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    sent++;
  endtask

  // hold the request side until every expected beat has come back
  task automatic wait_drained();
    req_ch.valid <= 1'b0;
    @(posedge clk);
    while (beats_owed != 0) @(posedge clk);
  endtask

  task automatic fill_table();
    int i;
    for (i = 0; i < CAPACITY + 2; i++) send_beat(CMD_ADD, pick_value());
    send_beat(CMD_LIST, pick_value());
  endtask

  initial begin
    int k;
    int n;
    int roll;
    int random_start;
    rst               <= 1'b1;
    calm              <= 1'b0;
    req_ch.valid      <= 1'b0;
    req_ch.cmd        <= CMD_ADD;
    req_ch.item_value <= '0;
    sent = 0;
    refresh_pool();
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // directed: empty table cases, extreme values, duplicates, spare codes
    send_beat(CMD_LIST, '0);
    send_beat(CMD_REMOVE, ALL_ONES);
    send_beat(CMD_COUNT, '0);
    send_beat(CMD_ADD, '0);
    send_beat(CMD_ADD, ALL_ONES);
    send_beat(CMD_ADD, '0);
    send_beat(CMD_COUNT, '0);
    send_beat(CMD_COUNT, ALL_ONES);
    send_beat(CMD_COUNT, 32'h5555_aaaa);
    send_beat(CMD_REMOVE, '0);
    send_beat(CMD_LIST, ALL_ONES);
    send_beat(CMD_REMOVE, 32'haaaa_5555);
    for (k = int'(CMD_SPARE_LO); k <= int'(CMD_SPARE_HI); k++) begin
      send_beat(CMD_W'(k), ALL_ONES);
    end
    send_beat(CMD_CLEAR, ALL_ONES);
    send_beat(CMD_LIST, '0);
    wait_drained();

    // random: a full table first, then mixed bursts of commands
    random_start = sent;
    fill_table();
    while (sent - random_start < RANDOM_ITEMS) begin
      calm <= (sent - random_start >= 200) && (sent - random_start < 290);
      roll = $urandom_range(99);
      if (roll < 30) begin
        n = $urandom_range(1, 6);
        repeat (n) send_beat(CMD_ADD, pick_value());
      end else if (roll < 34) begin
        fill_table();
      end else if (roll < 54) begin
        n = $urandom_range(1, 4);
        repeat (n) send_beat(CMD_REMOVE, pick_value());
      end else if (roll < 69) begin
        n = $urandom_range(1, 3);
        repeat (n) send_beat(CMD_COUNT, pick_value());
      end else if (roll < 82) begin
        send_beat(CMD_LIST, pick_value());
      end else if (roll < 89) begin
        send_beat(CMD_CLEAR, pick_value());
        refresh_pool();
      end else if (roll < 94) begin
        send_beat(CMD_W'($urandom_range(int'(CMD_SPARE_HI), int'(CMD_SPARE_LO))),
                  pick_value());
      end else begin
        wait_drained();
      end
    end

    // drain and let any stray beat show up
    calm <= 1'b0;
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule

`default_nettype wire

### multiset_bag_table.f
design/mbt_pkg.sv
design/mbt_if.sv
design/mbt_ram.sv
design/mbt_seq.sv
design/multiset_bag_table.sv
sim/bag_table_checker.sv
sim/testbench.sv
